// File: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker (thpt_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/thpt_pkg.sv
// Shared types, codes and constants of the turtle tracker.
`default_nettype none

package thpt_pkg;

    // command codes
    localparam logic [2:0] CMD_RESET    = 3'd0;
    localparam logic [2:0] CMD_PEN_UP   = 3'd1;
    localparam logic [2:0] CMD_PEN_DOWN = 3'd2;
    localparam logic [2:0] CMD_TURN     = 3'd3;
    localparam logic [2:0] CMD_MOVE     = 3'd4;

    // stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 168;
    localparam int OUT_TUSER_W = 2;

    // one full turn in whole degrees
    localparam logic [9:0] DEG_FULL_TURN = 10'd360;

    // CORDIC start vector (gain 0.60725 in Q2.30) and arctangents in binary-angle units
    localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
    localparam int          TABLE_LEN   = 30;
    localparam int          STEP_W      = 5;

    localparam logic [31:0] ATAN_BAM [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic [31:0] value;
        logic        clip;
    } t_sat;

    // 32-bit base plus 33-bit delta, clipped to the signed 32-bit range
    function automatic t_sat sat_add32(input logic [31:0] base, input logic [32:0] delta);
        logic [33:0] s;
        t_sat        r;
        s = {{2{base[31]}}, base} + {delta[32], delta};
        r.clip  = 1'b0;
        r.value = s[31:0];
        if (!s[33] && (s[32:31] != 2'b00)) begin
            r.clip  = 1'b1;
            r.value = 32'h7FFF_FFFF;
        end else if (s[33] && (s[32:31] != 2'b11)) begin
            r.clip  = 1'b1;
            r.value = 32'h8000_0000;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/thpt_angle_div.sv
// Heading to binary angle: digit-serial division of the scaled heading by 360.
`default_nettype none

module thpt_angle_div
    import thpt_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_heading,
    output logic             o_done,
    output logic [31:0]      o_theta
);

    localparam int SHIFT = 32 - FRACTION_BITS;
    localparam int DW    = 32 + SHIFT;
    localparam int DIGIT = 4;
    localparam int STEPS = (DW + DIGIT - 1) / DIGIT;
    localparam int DPW   = STEPS * DIGIT;
    localparam int CW    = $clog2(STEPS);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [DPW-1:0]  r_div;
    logic [8:0]      r_rem;
    logic [31:0]     r_quo;
    logic            r_neg;

    logic [8:0]      n_rem;
    logic [31:0]     n_quo;
    logic [31:0]     w_mag;
    logic [31:0]     w_q;

    assign w_mag = i_heading[31] ? (~i_heading + 32'd1) : i_heading;

    // DIGIT restoring steps per cycle on the narrow remainder
    always_comb begin
        logic [9:0] t;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIGIT; k++) begin
            t = {n_rem, r_div[DPW-1-k]};
            if (t >= DEG_FULL_TURN) begin
                n_rem = 9'(t - DEG_FULL_TURN);
                n_quo = {n_quo[30:0], 1'b1};
            end else begin
                n_rem = t[8:0];
                n_quo = {n_quo[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= DPW'(w_mag) << SHIFT;
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_heading[31];
        end else if (r_busy) begin
            r_div <= r_div << DIGIT;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // floor division for a negative heading: round the magnitude up, then negate
    assign w_q     = r_quo + {31'd0, (r_rem != 9'd0)};
    assign o_theta = r_neg ? (~w_q + 32'd1) : r_quo;
    assign o_done  = r_done;

endmodule

`default_nettype wire

// File: rtl/core/thpt_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine in Q2.30.
`default_nettype none

module thpt_cordic
    import thpt_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_theta,
    output logic             o_done,
    output logic [31:0]      o_cos,
    output logic [31:0]      o_sin
);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic signed [32:0]  r_a;
    logic signed [32:0]  r_b;
    logic signed [32:0]  r_z;
    logic                r_flip;

    logic                w_flip;
    logic signed [32:0]  w_sa;
    logic signed [32:0]  w_sb;
    logic signed [32:0]  w_at;
    logic signed [32:0]  w_neg_a;
    logic signed [32:0]  w_neg_b;

    // second and third quadrants are folded by half a turn
    assign w_flip  = (i_theta[31:30] == 2'b01) || (i_theta[31:30] == 2'b10);
    assign w_sa    = r_a >>> r_step;
    assign w_sb    = r_b >>> r_step;
    assign w_at    = {1'b0, ATAN_BAM[r_step]};
    assign w_neg_a = -r_a;
    assign w_neg_b = -r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= {1'b0, CORDIC_GAIN};
            r_b    <= '0;
            r_z    <= {i_theta[31] ^ w_flip, i_theta[31] ^ w_flip, i_theta[30:0]};
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_z[32]) begin
                r_a <= r_a - w_sb;
                r_b <= r_b + w_sa;
                r_z <= r_z - w_at;
            end else begin
                r_a <= r_a + w_sb;
                r_b <= r_b - w_sa;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_cos  = r_flip ? w_neg_a[31:0] : r_a[31:0];
    assign o_sin  = r_flip ? w_neg_b[31:0] : r_b[31:0];
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: rtl/core/turtle_heading_position_tracker.sv
// Top level of the turtle tracker: command sequencer, shared multiplier and state.
// Usage
//   Commands enter on the s_axis channel: tuser carries the command code
//   (reset, pen up, pen down, turn, move), tdata the signed Q16.16 amount.
//   Every command gives exactly one result beat on m_axis: position, heading,
//   pen state before the command and segment start in tdata, the draw and
//   clear-screen flags in tuser.
//   Timing: pen, reset, turn and unknown codes go from the input beat straight
//   to the final step, which registers the result beat. A move runs the angle
//   divider (four quotient bits a cycle), the CORDIC (one rotation a cycle)
//   and two passes of one 32x32 multiplier before its final step.
//   One command is in work at a time; s_axis_tready is high only while the
//   sequencer is idle, also while a finished result still waits on m_axis.
//   Reset: position and heading zero, pen down, no result pending.
//   Stall: a result held by a low m_axis_tready keeps its beat stable and the
//   next command waits at its final step until the output register frees.
`default_nettype none

module turtle_heading_position_tracker
    import thpt_pkg::*;
#(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [31:0] amount
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [2:0] command
    input  wire logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [31:0] new_x, [63:32] new_y, [95:64] heading_deg, [96] prior_pen,
    // [128:97] start_x, [160:129] start_y, [161] overflow, [167:162] zero
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // [0] draw_segment, [1] clear_screen
    output logic [OUT_TUSER_W-1:0]      o_m_axis_tuser
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ANGLE  = 3'd1;
    localparam logic [2:0] S_ROTATE = 3'd2;
    localparam logic [2:0] S_MULX   = 3'd3;
    localparam logic [2:0] S_MULY   = 3'd4;
    localparam logic [2:0] S_ADDY   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    // sequencer and turtle state
    logic [2:0]         r_state, n_state;
    logic [31:0]        r_pos_x, n_pos_x;
    logic [31:0]        r_pos_y, n_pos_y;
    logic [31:0]        r_heading, n_heading;
    logic               r_pen, n_pen;
    logic               r_out_valid;

    // working registers of one command
    logic [2:0]         r_cmd;
    logic signed [31:0] r_amt;
    logic signed [63:0] r_prod;
    logic [31:0]        r_nx;
    logic [31:0]        r_ny;
    logic               r_ovf_mv;
    logic [OUT_TDATA_W-1:0] r_tdata, n_tdata;
    logic [OUT_TUSER_W-1:0] r_tuser, n_tuser;

    logic               w_accept;
    logic               w_fire;
    logic               w_div_done;
    logic [31:0]        w_theta;
    logic               w_cor_done;
    logic [31:0]        w_cos;
    logic [31:0]        w_sin;
    logic [63:0]        w_round;
    logic [32:0]        w_delta;
    t_sat               w_step_sat;
    t_sat               w_turn_sat;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fire          = (r_state == S_FIN) && (!r_out_valid || i_m_axis_tready);

    thpt_angle_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_angle (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept && (i_s_axis_tuser == CMD_MOVE)),
        .i_heading (r_heading),
        .o_done    (w_div_done),
        .o_theta   (w_theta)
    );

    thpt_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_done),
        .i_theta (w_theta),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // round the Q2.30 product to the coordinate grid, ties up
    assign w_round    = r_prod + 64'sd536870912;
    assign w_delta    = w_round[62:30];
    assign w_step_sat = sat_add32((r_state == S_MULY) ? r_pos_x : r_pos_y, w_delta);
    assign w_turn_sat = sat_add32(r_heading, {r_amt[31], r_amt});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_s_axis_tuser == CMD_MOVE) ? S_ANGLE : S_FIN;
                end
            end
            S_ANGLE: begin
                if (w_div_done) begin
                    n_state = S_ROTATE;
                end
            end
            S_ROTATE: begin
                if (w_cor_done) begin
                    n_state = S_MULX;
                end
            end
            S_MULX:  n_state = S_MULY;
            S_MULY:  n_state = S_ADDY;
            S_ADDY:  n_state = S_FIN;
            S_FIN: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // final step: new state and the result beat
    always_comb begin
        logic        draw;
        logic        clr;
        logic        ovf;
        logic [31:0] sx;
        logic [31:0] sy;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_heading = r_heading;
        n_pen     = r_pen;
        draw      = 1'b0;
        clr       = 1'b0;
        ovf       = 1'b0;
        sx        = '0;
        sy        = '0;
        unique case (r_cmd)
            CMD_RESET: begin
                n_pos_x   = '0;
                n_pos_y   = '0;
                n_heading = '0;
                n_pen     = 1'b1;
                clr       = 1'b1;
            end
            CMD_PEN_UP:   n_pen = 1'b0;
            CMD_PEN_DOWN: n_pen = 1'b1;
            CMD_TURN: begin
                n_heading = w_turn_sat.value;
                ovf       = w_turn_sat.clip;
            end
            CMD_MOVE: begin
                n_pos_x = r_nx;
                n_pos_y = r_ny;
                ovf     = r_ovf_mv;
                draw    = r_pen;
                if (r_pen) begin
                    sx = r_pos_x;
                    sy = r_pos_y;
                end
            end
            default: begin
            end
        endcase
        n_tdata = {6'd0, ovf, sy, sx, r_pen, n_heading, n_pos_y, n_pos_x};
        n_tuser = {clr, draw};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_pen       <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_heading   <= n_heading;
                r_pen       <= n_pen;
            end
        end
    end

    // payload: one multiplier serves both axes, each sum is formed in the state after its product
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_s_axis_tuser;
            r_amt <= i_s_axis_tdata;
        end
        unique case (r_state)
            S_MULX: r_prod <= r_amt * signed'(w_cos);
            S_MULY: begin
                r_prod   <= r_amt * signed'(w_sin);
                r_nx     <= w_step_sat.value;
                r_ovf_mv <= w_step_sat.clip;
            end
            S_ADDY: begin
                r_ny     <= w_step_sat.value;
                r_ovf_mv <= r_ovf_mv | w_step_sat.clip;
            end
            default: begin
            end
        endcase
        if (w_fire) begin
            r_tdata <= n_tdata;
            r_tuser <= n_tuser;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tuser  = r_tuser;

endmodule

`default_nettype wire

// File: rtl/core/thpt_checker.sv
// Port-level checks of the turtle tracker, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module thpt_checker
    import thpt_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input wire logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    logic w_in_beat;
    logic w_out_wait;

    assign w_in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_wait = o_m_axis_tvalid && !i_m_axis_tready;

    // a stalled result beat stays put
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result beat changed under stall")

    // one command in work at a time
    `CHK_NEXT(a_one_cmd, i_clk, i_rst_n, w_in_beat, !o_s_axis_tready, "command taken while busy")

    // a clear-screen result shows the home position and draws nothing
    `CHK_SAME(a_clear_home, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[1], (o_m_axis_tdata[95:0] == 96'd0) && !o_m_axis_tuser[0], "clear result not at home")

    // a segment is drawn only with the pen down beforehand
    `CHK_SAME(a_draw_pen, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata[96], "segment drawn with pen up")

endmodule

bind turtle_heading_position_tracker thpt_checker u_thpt_checker (.*);

`default_nettype wire

// File: dv/turtle_track_checker.sv
// Checker for the turtle tracker: predicts each result beat and compares it with the output.
module turtle_track_checker
    import thpt_pkg::*;
#(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    // [31:0] amount
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [2:0] command
    input  wire logic [IN_TUSER_W-1:0]  i_s_tuser,
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    // [31:0] new_x, [63:32] new_y, [95:64] heading_deg, [96] prior_pen,
    // [128:97] start_x, [160:129] start_y, [161] overflow, [167:162] zero
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,
    // [0] draw_segment, [1] clear_screen
    input  wire logic [OUT_TUSER_W-1:0] i_m_tuser,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_clipped
);

    localparam int     ROTATIONS   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam longint FULL_TURN_Q = longint'(DEG_FULL_TURN) << FRACTION_BITS;
    localparam int     TRIG_SHIFT  = 30;
    localparam longint ROUND_HALF  = 64'sd1 << (TRIG_SHIFT - 1);
    localparam longint S32_MAX     = 64'sd2147483647;
    localparam longint S32_MIN     = -64'sd2147483648;
    localparam int     MAX_PRINTS  = 40;

    typedef struct packed {
        logic [31:0] new_x;
        logic [31:0] new_y;
        logic [31:0] heading_deg;
        logic        prior_pen;
        logic        draw_segment;
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic        clear_screen;
        logic        overflow;
    } turtle_pose_t;

    // tracked turtle state
    logic [31:0]  track_x;
    logic [31:0]  track_y;
    logic [31:0]  track_heading;
    logic         pen_is_down;

    turtle_pose_t pending_poses[$];
    turtle_pose_t next_pose;
    turtle_pose_t oldest_pose;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_clipped    = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < MAX_PRINTS)
            $display("%0t: mismatch in %s on result %0d: got %h, expected %h",
                     $time, what, o_checked, got, want);
        o_fail_count++;
    endtask

    function automatic t_sat clip_sum(input logic [31:0] base, input longint delta);
        longint s;
        t_sat   r;
        s      = longint'($signed(base)) + delta;
        r.clip = 1'b1;
        if (s > S32_MAX)
            r.value = 32'h7FFF_FFFF;
        else if (s < S32_MIN)
            r.value = 32'h8000_0000;
        else begin
            r.value = s[31:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

    // heading -> binary angle -> folded CORDIC, cos/sin in Q2.30
    function automatic void heading_sincos(input logic [31:0] hd, output longint cs,
                                           output longint sn);
        longint      r;
        logic [63:0] scaled;
        logic [31:0] theta;
        logic [31:0] t;
        logic        flip;
        longint      z;
        longint      a;
        longint      b;
        longint      na;
        longint      nb;
        int          k;
        r = longint'($signed(hd)) % FULL_TURN_Q;
        if (r < 0)
            r += FULL_TURN_Q;
        scaled = 64'(r) << (32 - FRACTION_BITS);
        theta  = 32'(scaled / 64'(DEG_FULL_TURN));
        // second and third quadrants are rotated by half a turn, result negated
        flip   = (theta[31:30] == 2'b01) || (theta[31:30] == 2'b10);
        t      = flip ? theta + 32'h8000_0000 : theta;
        z      = longint'($signed(t));
        a      = longint'(CORDIC_GAIN);
        b      = 0;
        for (k = 0; k < ROTATIONS; k++) begin
            if (z >= 0) begin
                na = a - (b >>> k);
                nb = b + (a >>> k);
                z  = z - longint'(ATAN_BAM[k]);
            end else begin
                na = a + (b >>> k);
                nb = b - (a >>> k);
                z  = z + longint'(ATAN_BAM[k]);
            end
            a = na;
            b = nb;
        end
        cs = flip ? -a : a;
        sn = flip ? -b : b;
    endfunction

    function automatic turtle_pose_t advance_turtle(input logic [2:0] cmd,
                                                    input logic [31:0] amount);
        turtle_pose_t p;
        t_sat         sx;
        t_sat         sy;
        t_sat         sh;
        longint       amt;
        longint       cs;
        longint       sn;
        longint       dx;
        longint       dy;
        p           = '0;
        p.prior_pen = pen_is_down;
        amt         = longint'($signed(amount));
        case (cmd)
            CMD_RESET: begin
                track_x        = '0;
                track_y        = '0;
                track_heading  = '0;
                pen_is_down    = 1'b1;
                p.clear_screen = 1'b1;
            end
            CMD_PEN_UP:   pen_is_down = 1'b0;
            CMD_PEN_DOWN: pen_is_down = 1'b1;
            CMD_TURN: begin
                sh            = clip_sum(track_heading, amt);
                track_heading = sh.value;
                p.overflow    = sh.clip;
            end
            CMD_MOVE: begin
                heading_sincos(track_heading, cs, sn);
                dx = (amt * cs + ROUND_HALF) >>> TRIG_SHIFT;
                dy = (amt * sn + ROUND_HALF) >>> TRIG_SHIFT;
                if (pen_is_down) begin
                    p.draw_segment = 1'b1;
                    p.start_x      = track_x;
                    p.start_y      = track_y;
                end
                sx         = clip_sum(track_x, dx);
                sy         = clip_sum(track_y, dy);
                track_x    = sx.value;
                track_y    = sy.value;
                p.overflow = sx.clip | sy.clip;
            end
            default: ;  // unused codes leave the state alone
        endcase
        p.new_x       = track_x;
        p.new_y       = track_y;
        p.heading_deg = track_heading;
        return p;
    endfunction

    task automatic compare_pose(input logic [OUT_TDATA_W-1:0] d,
                                input logic [OUT_TUSER_W-1:0] u, input turtle_pose_t w);
        if (d[31:0] !== w.new_x)          report_mismatch("new_x", d[31:0], w.new_x);
        if (d[63:32] !== w.new_y)         report_mismatch("new_y", d[63:32], w.new_y);
        if (d[95:64] !== w.heading_deg)   report_mismatch("heading_deg", d[95:64], w.heading_deg);
        if (d[96] !== w.prior_pen)        report_mismatch("prior_pen", 32'(d[96]), 32'(w.prior_pen));
        if (d[128:97] !== w.start_x)      report_mismatch("start_x", d[128:97], w.start_x);
        if (d[160:129] !== w.start_y)     report_mismatch("start_y", d[160:129], w.start_y);
        if (d[161] !== w.overflow)        report_mismatch("overflow", 32'(d[161]), 32'(w.overflow));
        if (d[167:162] !== '0)            report_mismatch("tdata padding", 32'(d[167:162]), '0);
        if (u[0] !== w.draw_segment)
            report_mismatch("draw_segment", 32'(u[0]), 32'(w.draw_segment));
        if (u[1] !== w.clear_screen)
            report_mismatch("clear_screen", 32'(u[1]), 32'(w.clear_screen));
    endtask

    // results are taken before commands so a beat can never match its own command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            track_x       = '0;
            track_y       = '0;
            track_heading = '0;
            pen_is_down   = 1'b1;
            pending_poses.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_poses.size() == 0) begin
                    report_mismatch("result beat with nothing expected", i_m_tdata[31:0], '0);
                end else begin
                    oldest_pose = pending_poses.pop_front();
                    compare_pose(i_m_tdata, i_m_tuser, oldest_pose);
                    o_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                next_pose = advance_turtle(i_s_tuser, i_s_tdata);
                pending_poses.push_back(next_pose);
                if (next_pose.overflow)
                    o_clipped++;
            end
        end
        o_pending = pending_poses.size();
    end

endmodule

// File: dv/tb_turtle_heading_position_tracker.sv
// Testbench top for the turtle tracker: clock, reset, command stimulus, result sink and verdict.
module tb_turtle_heading_position_tracker;
    import thpt_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int CORDIC_ITERS   = 16;
    localparam int FRAC_BITS      = 16;
    localparam int ONE_Q          = 1 << FRAC_BITS;
    localparam int RANDOM_ITEMS   = 1525;
    localparam int PAUSE_AT       = 700;   // sender waits for a full drain here
    localparam int HOLD_AT        = 200;   // result count at which the sink holds off
    localparam int HOLD_CYCLES    = 600;
    localparam int MAX_GAP        = 12;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 5000;

    // codes past the last defined command
    localparam logic [2:0] UNUSED_LO = CMD_MOVE + 3'd1;
    localparam logic [2:0] UNUSED_HI = 3'd7;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    int fail_count;
    int pending;
    int checked;
    int clipped;
    int idle_cycles  = 0;
    int send_quiet   = 0;
    int sink_quiet   = 0;
    int sent_by_code[8];

    always #(CLK_PERIOD / 2) clk = ~clk;

    turtle_heading_position_tracker #(
        .CORDIC_STEPS  (CORDIC_ITERS),
        .FRACTION_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    turtle_track_checker #(
        .CORDIC_STEPS  (CORDIC_ITERS),
        .FRACTION_BITS (FRAC_BITS)
    ) u_track_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_clipped    (clipped)
    );

    // Gap before the next beat on either side. Now and then a run of
    // back-to-back beats, so both the busy and the idle cases get exercised.
    function automatic int next_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            quiet_left = $urandom_range(20, 60);
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Mostly moves and turns; resets kept rare so the position can wander.
    function automatic logic [2:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return CMD_RESET;
        if (r < 12) return CMD_PEN_UP;
        if (r < 20) return CMD_PEN_DOWN;
        if (r < 45) return CMD_TURN;
        if (r < 93) return CMD_MOVE;
        return 3'(UNUSED_LO + $urandom_range(0, UNUSED_HI - UNUSED_LO));
    endfunction

    // Amounts: mostly modest values, sometimes exact quadrant turns,
    // sometimes the limits of the field or fully random words.
    function automatic logic [31:0] pick_amount(input logic [2:0] cmd);
        int r;
        int k;
        if (cmd != CMD_TURN && cmd != CMD_MOVE)
            return $urandom;    // ignored by the block, but toggles the bus
        r = $urandom_range(0, 23);
        if (r == 0) return 32'h7FFF_FFFF;
        if (r == 1) return 32'h8000_0000;
        if (r == 2) return $urandom;
        if (r == 3) return '0;
        if (r == 4) return $urandom_range(0, 1) ? 32'd1 : '1;
        if (cmd == CMD_TURN) begin
            if (r < 9) begin
                k = $urandom_range(0, 8);
                return 32'((k - 4) * 90 * ONE_Q);
            end
            return 32'($urandom_range(0, 800 * ONE_Q) - 400 * ONE_Q);
        end
        return 32'($urandom_range(0, 400 * ONE_Q) - 200 * ONE_Q);
    endfunction

    // Offer one command beat and return at the edge where it is taken.
    // Valid stays high across back-to-back beats.
    task automatic offer_command(input logic [2:0] cmd, input logic [31:0] amount);
        int gap;
        gap = next_gap(send_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= amount;
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        sent_by_code[cmd]++;
    endtask

    // Stop offering and wait until every expected result has been taken.
    // The count is looked at on the falling edge, clear of the checker's update.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // Command side.
    initial begin : command_source
        logic [2:0] cmd;
        int         unused;
        int         total;
        int         c;
        unused = 0;
        total  = 0;
        foreach (sent_by_code[c]) sent_by_code[c] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed part: pen states, each quadrant, negative heading,
        // position and heading clipping at both limits, unused codes, reset
        offer_command(CMD_PEN_UP, 32'hDEAD_BEEF);
        offer_command(CMD_MOVE, 32'(10 * ONE_Q));          // move with the pen up
        offer_command(CMD_PEN_DOWN, '0);
        offer_command(CMD_TURN, 32'(90 * ONE_Q));
        offer_command(CMD_MOVE, 32'(5 * ONE_Q + ONE_Q / 2));
        offer_command(CMD_TURN, 32'(90 * ONE_Q));
        offer_command(CMD_MOVE, 32'(ONE_Q));
        offer_command(CMD_TURN, 32'(90 * ONE_Q));
        offer_command(CMD_MOVE, 32'(-3 * ONE_Q - ONE_Q / 4));
        offer_command(CMD_TURN, 32'(-315 * ONE_Q - ONE_Q / 2));
        offer_command(CMD_MOVE, '0);
        offer_command(CMD_MOVE, 32'h7FFF_FFFF);
        offer_command(CMD_MOVE, 32'h7FFF_FFFF);            // x clips high
        offer_command(CMD_MOVE, 32'h8000_0000);
        offer_command(CMD_RESET, '1);
        offer_command(CMD_TURN, 32'h7FFF_FFFF);
        offer_command(CMD_TURN, 32'h7FFF_FFFF);            // heading clips high
        offer_command(CMD_MOVE, 32'(ONE_Q));
        offer_command(CMD_TURN, 32'h8000_0000);
        offer_command(CMD_TURN, 32'h8000_0000);            // heading clips low
        offer_command(CMD_MOVE, 32'h8000_0000);
        for (cmd = UNUSED_LO; cmd != UNUSED_LO - 3'd1; cmd++) begin
            offer_command(cmd, $urandom);
            if (cmd == UNUSED_HI)
                break;
        end
        offer_command(CMD_RESET, '0);
        drain_results();

        // random part
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PAUSE_AT)
                drain_results();
            cmd = pick_command();
            offer_command(cmd, pick_amount(cmd));
        end
        drain_results();

        // room for any stray beat the block might still put out
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        for (c = UNUSED_LO; c <= UNUSED_HI; c++) unused += sent_by_code[c];
        foreach (sent_by_code[c]) total += sent_by_code[c];
        $display("covered %0d commands: %0d resets, %0d pen up, %0d pen down, %0d turns, %0d moves, %0d unused codes",
                 total, sent_by_code[CMD_RESET], sent_by_code[CMD_PEN_UP],
                 sent_by_code[CMD_PEN_DOWN], sent_by_code[CMD_TURN], sent_by_code[CMD_MOVE],
                 unused);
        $display("%0d result beats checked, %0d with clipping; one long output stall, one full drain pause",
                 checked, clipped);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("** turtle_heading_position_tracker: PASSED **");
        else
            $display("** turtle_heading_position_tracker: FAILED **");
        $finish;
    end

    // Result side: random stalls per beat, and once a long hold-off while
    // commands keep coming, so the block fills and stops taking input.
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (taken == HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                stall = next_gap(sink_quiet);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
        end
    end

    // Watchdog: a stretch with no beat on either side means a hang.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, pending);
                $display("** turtle_heading_position_tracker: FAILED **");
                $finish;
            end
        end
    end

endmodule
